FILE: design/smpq_pkg.sv
`default_nettype none
package smpq_pkg;

  localparam int unsigned SMPQ_DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_POP_EMPTY  = 2'd2;

  // Operation broadcast to every cell in a cycle
  typedef struct packed {
    logic push;
    logic pop;
  } smpq_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] head_value;
    logic                     head_valid;
    logic [COUNT_W-1:0]       entry_count;
    logic [STAT_W-1:0]        status;
  } smpq_res_t;

endpackage
`default_nettype wire

FILE: design/smpq_cell.sv
`default_nettype none
module smpq_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire smpq_pkg::smpq_op_t               op,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] push_value,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] left_value,
  input  wire logic                             left_valid,
  input  wire logic                             left_gt,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] right_value,
  input  wire logic                             right_valid,
  output logic signed [smpq_pkg::DATA_W-1:0]    value_r,
  output logic                                  valid_r,
  output logic                                  gt,
  output logic signed [smpq_pkg::DATA_W-1:0]    value_nxt,
  output logic                                  valid_nxt
);
  import smpq_pkg::*;

  // Entry stays put when it beats the pushed value; list is sorted so this
  // is a prefix of the chain.
  assign gt = valid_r && (value_r > push_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (op.push) begin
      if (!gt) begin
        value_nxt = left_gt ? push_value : left_value;
      end
      valid_nxt = left_valid;
    end else if (op.pop) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/sorted_max_priority_queue.sv
// A request's result is registered (output or skid register) before it shows on out_*.
// Throughput: one request per cycle while in_stall is low; every cell compares against
// the pushed value in parallel and shifts one place toward its neighbor in the same cycle.
// A two-entry output stage (result register plus skid register) absorbs out_stall.
// Reset: entry valid bits, fill count and output valid flags clear; stored values do not.
`default_nettype none
module sorted_max_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = smpq_pkg::SMPQ_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_command,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] in_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [smpq_pkg::DATA_W-1:0]    out_head_value,
  output logic                                  out_head_valid,
  output logic [smpq_pkg::COUNT_W-1:0]          out_entry_count,
  output logic [smpq_pkg::STAT_W-1:0]           out_status
);
  import smpq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [DATA_W-1:0] val     [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] val_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   vld;
  logic [QUEUE_DEPTH-1:0]   vld_nxt;
  logic [QUEUE_DEPTH-1:0]   gt;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          accept;
  logic          full;
  logic          empty;
  smpq_op_t      op;
  smpq_res_t     res_nxt;
  smpq_res_t     out_r;
  smpq_res_t     skid_r;
  logic          out_valid_r;
  logic          skid_valid_r;
  logic          take;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign full     = vld[QUEUE_DEPTH-1];
  assign empty    = !vld[0];

  assign op.push = accept && (in_command == CMD_PUSH) && !full;
  assign op.pop  = accept && (in_command == CMD_POP) && !empty;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] l_val;
      logic                     l_vld;
      logic                     l_gt;
      logic signed [DATA_W-1:0] r_val;
      logic                     r_vld;

      if (i == 0) begin : g_first
        assign l_val = in_value;
        assign l_vld = 1'b1;
        assign l_gt  = 1'b1;
      end else begin : g_mid
        assign l_val = val[i-1];
        assign l_vld = vld[i-1];
        assign l_gt  = gt[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign r_val = val[i];
        assign r_vld = 1'b0;
      end else begin : g_inner
        assign r_val = val[i+1];
        assign r_vld = vld[i+1];
      end

      smpq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .push_value  (in_value),
        .left_value  (l_val),
        .left_valid  (l_vld),
        .left_gt     (l_gt),
        .right_value (r_val),
        .right_valid (r_vld),
        .value_r     (val[i]),
        .valid_r     (vld[i]),
        .gt          (gt[i]),
        .value_nxt   (val_nxt[i]),
        .valid_nxt   (vld_nxt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (op.push) begin
      count_nxt = count_r + CW'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    res_nxt.head_valid  = vld_nxt[0];
    res_nxt.head_value  = vld_nxt[0] ? val_nxt[0] : '0;
    res_nxt.entry_count = COUNT_W'(count_nxt);
    res_nxt.status      = STATUS_OK;
    if (in_command == CMD_PUSH && full) begin
      res_nxt.status = STATUS_FULL;
    end else if (in_command == CMD_POP && empty) begin
      res_nxt.status = STATUS_POP_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res_nxt;
      end
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_value  = out_r.head_value;
  assign out_head_valid  = out_r.head_valid;
  assign out_entry_count = out_r.entry_count;
  assign out_status      = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(vld)))
    else $error("fill count disagrees with cell valid bits");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    vld[1] |-> (val[0] >= val[1]))
    else $error("head entry smaller than its successor");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    op.push |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not add an entry");

endmodule
`default_nettype wire
